FILE: rtl/lmsc_pkg.sv
// lmsc_pkg: shared types and constants for the LED matrix scan controller.
// No dependencies; compiled first.
package lmsc_pkg;

	localparam int OP_W        = 3;
	localparam int COORD_W     = 3;
	localparam int LOAD_W      = 5;
	localparam int LOAD_INPUTS = 5;
	localparam int ACT_W       = 3;
	localparam int DRIVE_W     = 5;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
	localparam logic [OP_W-1:0] OP_PIXEL = 3'd3;
	localparam logic [OP_W-1:0] OP_SHR   = 3'd4;
	localparam logic [OP_W-1:0] OP_SHL   = 3'd5;

	// One registered request, as seen by the frame store.
	typedef struct packed {
		logic                                  en;
		logic [OP_W-1:0]                       operation;
		logic [COORD_W-1:0]                    pixel_x;
		logic [COORD_W-1:0]                    pixel_y;
		logic                                  pixel_on;
		logic [LOAD_INPUTS-1:0][LOAD_W-1:0]    load_rows;
	} frame_cmd_t;

	// Top level to scan stage.
	typedef struct packed {
		logic tick_go;
	} scan_ctl_t;

	// Scan stage to top level.
	typedef struct packed {
		logic out_free;
	} scan_sts_t;

endpackage

FILE: rtl/lmsc_in_if.sv
// lmsc_in_if: request channel (valid/ready plus operation payload).
// Depends on lmsc_pkg.
interface lmsc_in_if import lmsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic               pixel_on;
	logic [LOAD_W-1:0]  load_row_0;
	logic [LOAD_W-1:0]  load_row_1;
	logic [LOAD_W-1:0]  load_row_2;
	logic [LOAD_W-1:0]  load_row_3;
	logic [LOAD_W-1:0]  load_row_4;

	modport source (
		output valid, operation, pixel_x, pixel_y, pixel_on,
		output load_row_0, load_row_1, load_row_2, load_row_3, load_row_4,
		input  ready
	);
	modport sink (
		input  valid, operation, pixel_x, pixel_y, pixel_on,
		input  load_row_0, load_row_1, load_row_2, load_row_3, load_row_4,
		output ready
	);
endinterface

FILE: rtl/lmsc_out_if.sv
// lmsc_out_if: result channel (valid/ready plus row and column drive).
// Depends on lmsc_pkg.
interface lmsc_out_if import lmsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   active_row;
	logic [DRIVE_W-1:0] row_drive;
	logic [DRIVE_W-1:0] column_drive_low;

	modport source (
		output valid, active_row, row_drive, column_drive_low,
		input  ready
	);
	modport sink (
		input  valid, active_row, row_drive, column_drive_low,
		output ready
	);
endinterface

FILE: rtl/lmsc_frame.sv
// lmsc_frame: frame register file, ROW_COUNT rows of COLUMN_COUNT bits.
// Applies load/clear/pixel/shift commands; one read port for the scan stage.
// Depends on lmsc_pkg.
module lmsc_frame import lmsc_pkg::*; #(
	parameter int ROW_COUNT    = 5,
	parameter int COLUMN_COUNT = 5,
	parameter int ROW_W        = $clog2(ROW_COUNT)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  frame_cmd_t              cmd,
	input  logic [ROW_W-1:0]        rd_idx,
	output logic [COLUMN_COUNT-1:0] rd_row
);

	logic [COLUMN_COUNT-1:0] rows_q [ROW_COUNT];
	logic [COLUMN_COUNT-1:0] rows_d [ROW_COUNT];
	logic [COLUMN_COUNT-1:0] pix_mask;
	logic                    px_ok;

	// Column c of a row is bit COLUMN_COUNT-1-c.
	always_comb begin
		px_ok = (32'(cmd.pixel_x) < COLUMN_COUNT);
		for (int b = 0; b < COLUMN_COUNT; b++) begin
			pix_mask[b] = px_ok && (32'(cmd.pixel_x) == COLUMN_COUNT - 1 - b);
		end
	end

	always_comb begin
		for (int r = 0; r < ROW_COUNT; r++) begin
			rows_d[r] = rows_q[r];
			case (cmd.operation)
				OP_LOAD: begin
					if (r < LOAD_INPUTS) begin
						rows_d[r] = COLUMN_COUNT'(cmd.load_rows[r[2:0]]);
					end else begin
						rows_d[r] = '0;
					end
				end
				OP_CLEAR: rows_d[r] = '0;
				OP_PIXEL: begin
					if (32'(cmd.pixel_y) == r) begin
						rows_d[r] = cmd.pixel_on ? (rows_q[r] | pix_mask)
						                         : (rows_q[r] & ~pix_mask);
					end
				end
				OP_SHR:  rows_d[r] = rows_q[r] >> 1;
				OP_SHL:  rows_d[r] = rows_q[r] << 1;
				default: rows_d[r] = rows_q[r];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) rows_q[r] <= '0;
		end else if (cmd.en) begin
			for (int r = 0; r < ROW_COUNT; r++) rows_q[r] <= rows_d[r];
		end
	end

	assign rd_row = rows_q[rd_idx];

endmodule

FILE: rtl/lmsc_scan.sv
// lmsc_scan: row scan counter and result register.
// Builds row/column drive for the next row on each tick. Depends on lmsc_pkg, lmsc_out_if.
module lmsc_scan import lmsc_pkg::*; #(
	parameter int ROW_COUNT    = 5,
	parameter int COLUMN_COUNT = 5,
	parameter int ROW_W        = $clog2(ROW_COUNT)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_ctl_t               ctl,
	output scan_sts_t               sts,
	output logic [ROW_W-1:0]        rd_idx,
	input  logic [COLUMN_COUNT-1:0] rd_row,
	lmsc_out_if.source              result
);

	logic [ROW_W-1:0]   scan_row_q;
	logic [ROW_W-1:0]   scan_nxt;
	logic [31:0]        nxt_wide;
	logic [DRIVE_W-1:0] row_drv;
	logic [DRIVE_W-1:0] col_drv;
	logic               valid_q;
	logic [ACT_W-1:0]   active_row_q;
	logic [DRIVE_W-1:0] row_drive_q;
	logic [DRIVE_W-1:0] column_drive_low_q;

	assign scan_nxt = (32'(scan_row_q) == ROW_COUNT - 1) ? '0 : scan_row_q + 1'b1;
	assign nxt_wide = 32'(scan_nxt);
	assign rd_idx   = scan_nxt;

	always_comb begin
		for (int b = 0; b < DRIVE_W; b++) row_drv[b] = (nxt_wide == b);
	end

	// Columns past the matrix width stay dark.
	for (genvar i = 0; i < DRIVE_W; i++) begin : g_col
		if (i < COLUMN_COUNT) begin : g_live
			assign col_drv[i] = ~rd_row[COLUMN_COUNT-1-i];
		end else begin : g_dark
			assign col_drv[i] = 1'b1;
		end
	end

	assign sts.out_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (ctl.tick_go) begin
				scan_row_q <= scan_nxt;
				valid_q    <= 1'b1;
			end else if (result.ready) begin
				valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick_go) begin
			active_row_q       <= nxt_wide[ACT_W-1:0];
			row_drive_q        <= row_drv;
			column_drive_low_q <= col_drv;
		end
	end

	assign result.valid            = valid_q;
	assign result.active_row       = active_row_q;
	assign result.row_drive        = row_drive_q;
	assign result.column_drive_low = column_drive_low_q;

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_row_q) < ROW_COUNT)
		else $error("scan row out of range");

	a_tick_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick_go |-> sts.out_free)
		else $error("tick issued while result register held");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick_go |=> valid_q && $onehot0(row_drive_q)
		&& (32'(scan_row_q) == 32'(active_row_q) || ROW_W > ACT_W))
		else $error("tick result inconsistent with scan row");

endmodule

FILE: rtl/led_matrix_scan_controller.sv
// led_matrix_scan_controller: top level of the 5x5 LED matrix row scan controller.
// Depends on lmsc_pkg, lmsc_in_if, lmsc_out_if, lmsc_frame, lmsc_scan.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  request  | in  | valid / ready | operation, pixel_x/y, pixel_on, load_row_0..4
//  result   | out | valid / ready | active_row, row_drive, column_drive_low
//
// Each request is registered (stage 1) and applied to the frame and scan counter
// as it leaves stage 1, and a tick's result is then registered in the result
// register; one request is taken every cycle while no tick waits in stage 1.
// A tick in stage 1 waits only while the result register is full and not being
// taken; other operations never wait. Reset (arst_n, async) clears the frame,
// the scan row and all valid bits; the first tick drives row 1.
module led_matrix_scan_controller import lmsc_pkg::*; #(
	parameter int ROW_COUNT    = 5,
	parameter int COLUMN_COUNT = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	lmsc_in_if.sink    request,
	lmsc_out_if.source result
);

	localparam int ROW_W = $clog2(ROW_COUNT);

	// Stage 1: registered request.
	logic                                valid_s1;
	logic [OP_W-1:0]                     operation_s1;
	logic [COORD_W-1:0]                  pixel_x_s1;
	logic [COORD_W-1:0]                  pixel_y_s1;
	logic                                pixel_on_s1;
	logic [LOAD_INPUTS-1:0][LOAD_W-1:0]  load_rows_s1;

	logic                    is_tick;
	logic                    advance;
	frame_cmd_t              fcmd;
	scan_ctl_t               sctl;
	scan_sts_t               ssts;
	logic [ROW_W-1:0]        rd_idx;
	logic [COLUMN_COUNT-1:0] rd_row;

	assign is_tick       = (operation_s1 == OP_TICK);
	// A tick only moves on when its result has a place to go.
	assign advance       = valid_s1 && (!is_tick || ssts.out_free);
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			operation_s1    <= request.operation;
			pixel_x_s1      <= request.pixel_x;
			pixel_y_s1      <= request.pixel_y;
			pixel_on_s1     <= request.pixel_on;
			load_rows_s1[0] <= request.load_row_0;
			load_rows_s1[1] <= request.load_row_1;
			load_rows_s1[2] <= request.load_row_2;
			load_rows_s1[3] <= request.load_row_3;
			load_rows_s1[4] <= request.load_row_4;
		end
	end

	// Frame sees every advancing request; ticks and unused codes leave it alone.
	assign fcmd.en        = advance;
	assign fcmd.operation = operation_s1;
	assign fcmd.pixel_x   = pixel_x_s1;
	assign fcmd.pixel_y   = pixel_y_s1;
	assign fcmd.pixel_on  = pixel_on_s1;
	assign fcmd.load_rows = load_rows_s1;

	assign sctl.tick_go = advance && is_tick;

	lmsc_frame #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT),
		.ROW_W        (ROW_W)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fcmd),
		.rd_idx (rd_idx),
		.rd_row (rd_row)
	);

	lmsc_scan #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT),
		.ROW_W        (ROW_W)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.sts    (ssts),
		.rd_idx (rd_idx),
		.rd_row (rd_row),
		.result (result)
	);

endmodule
